/* sv/sbig_pkg.sv */
// Shared types and constants for the shuffled batch index generator.
// No dependencies.
package sbig_pkg;

   localparam int RANDOM_W    = 64;
   localparam int IDX_W       = 28;
   localparam int BCOUNT_W    = 13;
   localparam int BSTRIDE_W   = 17;
   localparam int LBLOCKS_W   = 7;
   localparam int SCOUNT_W    = 11;
   localparam int SFIRST_W    = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BATCH_COUNT       = 3'd0,
      REG_BLOCKS_IN_BATCH   = 3'd1,
      REG_BLOCKS_IN_LOCAL   = 3'd2,
      REG_SHARD_COUNT       = 3'd3,
      REG_FIRST_SHARD       = 3'd4
   } csr_reg_type;

endpackage

/* sv/sbig_mod.sv */
// Bit-serial restoring modulo: 64-bit dividend by a narrow divisor, one bit per cycle.
// Depends on sbig_pkg.
module sbig_mod
   import sbig_pkg::*;
#(
   parameter int DIV_W = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RANDOM_W-1:0] dividend,
   input  logic [DIV_W-1:0]    divisor,
   output logic                done,
   output logic [DIV_W-1:0]    remainder
);

   localparam int CNT_W = $clog2(RANDOM_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [RANDOM_W-1:0] dvd_ff;
   logic [DIV_W-1:0]    dvs_ff;
   logic [DIV_W-1:0]    rem_ff;
   logic [DIV_W:0]      trial;
   logic [DIV_W-1:0]    rem_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[RANDOM_W-1]};
      if (trial >= {1'b0, dvs_ff}) begin
         trial = trial - {1'b0, dvs_ff};
      end
      rem_in = trial[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[RANDOM_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RANDOM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* sv/shuffled_batch_index_generator_core.sv */
// Core of the shuffled batch index generator; uses sbig_pkg and the sbig_mod serial modulo.
// Steps: the serial modulo, then the table read, swap and multiply, then the add; then one
// result per cycle, local count times. A new transaction is accepted only in idle, once the
// last one is through; at epoch wrap the shard rotation reuses the modulo, stretching the
// transaction; results never stall.
// Reset: synchronous; a clearing pass over every table entry follows with busy high.
module shuffled_batch_index_generator_core
   import sbig_pkg::*;
#(
   parameter int MAX_BATCHES      = 4096,
   parameter int MAX_LOCAL_BLOCKS = 64,
   parameter int MAX_SHARDS       = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [RANDOM_W-1:0]   req_random_word,
   output logic                  rsp_valid,
   output logic [IDX_W-1:0]      rsp_block_index,
   output logic                  rsp_last_block,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = $clog2(MAX_BATCHES);
   localparam int CW    = $clog2(MAX_BATCHES + 1);
   localparam int ESW   = $clog2(MAX_SHARDS + 1);
   localparam int SW    = ($clog2(MAX_SHARDS) > SFIRST_W) ? $clog2(MAX_SHARDS) : SFIRST_W;
   localparam int DW    = (CW > ESW) ? CW : ESW;
   localparam int LW    = $clog2(MAX_LOCAL_BLOCKS + 1);
   localparam int PA_W  = AW + BSTRIDE_W;
   localparam int PB_W  = SW + LBLOCKS_W;
   localparam int SUM_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MOD, S_RD_T, S_RD_P, S_WR_T, S_WR_P, S_ADD, S_EMIT, S_DRAIN
   } state_type;

   state_type st_ff;

   logic [BCOUNT_W-1:0]  bcount_ff;
   logic [BSTRIDE_W-1:0] bstride_ff;
   logic [LBLOCKS_W-1:0] lblocks_ff;
   logic [SCOUNT_W-1:0]  scount_ff;

   logic [AW-1:0]    clr_ff;
   logic [AW-1:0]    pos_ff;
   logic [AW-1:0]    tgt_ff;
   logic [AW-1:0]    tval_ff;
   logic [SW-1:0]    shard_ff;
   logic             shard_run_ff;
   logic [PA_W-1:0]  prod_a_ff;
   logic [PB_W-1:0]  prod_b_ff;
   logic [LW-1:0]    cnt_ff;
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic             rsp_last_ff;

   logic [AW-1:0] order_mem [MAX_BATCHES];
   logic [AW-1:0] mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;

   logic [CW-1:0]       count_eff;
   logic [ESW-1:0]      shards_eff;
   logic [LW-1:0]       local_eff;
   logic [AW-1:0]       pos_eff;
   logic [CW-1:0]       pos_next;
   logic                wrap;
   logic [SW:0]         shard_inc;
   logic [SUM_W-1:0]    base_sum;
   logic                accept;
   logic                csr_wr;
   logic                div_start;
   logic [RANDOM_W-1:0] div_dividend;
   logic [DW-1:0]       div_divisor;
   logic                div_done;
   logic [DW-1:0]       div_rem;

   always_comb begin
      if (bcount_ff == '0) begin
         count_eff = CW'(1);
      end else if (32'(bcount_ff) > MAX_BATCHES) begin
         count_eff = CW'(MAX_BATCHES);
      end else begin
         count_eff = CW'(bcount_ff);
      end
      if (scount_ff == '0) begin
         shards_eff = ESW'(1);
      end else if (32'(scount_ff) > MAX_SHARDS) begin
         shards_eff = ESW'(MAX_SHARDS);
      end else begin
         shards_eff = ESW'(scount_ff);
      end
      if (32'(lblocks_ff) > MAX_LOCAL_BLOCKS) begin
         local_eff = LW'(MAX_LOCAL_BLOCKS);
      end else begin
         local_eff = LW'(lblocks_ff);
      end
      pos_eff   = (CW'(pos_ff) >= count_eff) ? '0 : pos_ff;
      pos_next  = CW'(pos_ff) + CW'(1);
      wrap      = pos_next >= count_eff;
      shard_inc = (SW + 1)'(shard_ff) + (SW + 1)'(1);
      base_sum  = SUM_W'(prod_a_ff) + SUM_W'(prod_b_ff);
   end

   assign accept    = start && (st_ff == S_IDLE);
   assign csr_wr    = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign busy      = (st_ff != S_IDLE);

   assign div_start    = accept || ((st_ff == S_ADD) && wrap);
   assign div_dividend = (st_ff == S_IDLE) ? req_random_word : RANDOM_W'(shard_inc);
   assign div_divisor  = (st_ff == S_IDLE) ? (DW'(count_eff) - DW'(pos_eff))
                                           : DW'(shards_eff);

   sbig_mod #(
      .DIV_W(DW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = tval_ff;
      unique case (st_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = clr_ff;
         end
         S_WR_T: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = mem_rdata_ff;
         end
         S_WR_P: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      mem_raddr = (st_ff == S_RD_T) ? tgt_ff : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         order_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= order_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         shard_ff     <= '0;
         shard_run_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bcount_ff    <= BCOUNT_W'(1);
         bstride_ff   <= BSTRIDE_W'(1);
         lblocks_ff   <= LBLOCKS_W'(1);
         scount_ff    <= SCOUNT_W'(1);
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               REG_BATCH_COUNT:     bcount_ff  <= csr_wdata[BCOUNT_W-1:0];
               REG_BLOCKS_IN_BATCH: bstride_ff <= csr_wdata[BSTRIDE_W-1:0];
               REG_BLOCKS_IN_LOCAL: lblocks_ff <= csr_wdata[LBLOCKS_W-1:0];
               REG_SHARD_COUNT:     scount_ff  <= csr_wdata[SCOUNT_W-1:0];
               REG_FIRST_SHARD:     shard_ff   <= SW'(csr_wdata[SFIRST_W-1:0]);
               default: ;
            endcase
         end
         if (shard_run_ff && div_done) begin
            shard_run_ff <= 1'b0;
            shard_ff     <= SW'(div_rem);
         end

         unique case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_BATCHES - 1)) begin
                  st_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  pos_ff <= pos_eff;
                  st_ff  <= S_MOD;
               end
            end
            S_MOD: begin
               if (div_done) begin
                  tgt_ff <= AW'(div_rem) + pos_ff;
                  st_ff  <= S_RD_T;
               end
            end
            S_RD_T: begin
               st_ff <= S_RD_P;
            end
            S_RD_P: begin
               tval_ff <= mem_rdata_ff;
               st_ff   <= S_WR_T;
            end
            S_WR_T: begin
               st_ff <= S_WR_P;
            end
            S_WR_P: begin
               prod_a_ff <= PA_W'(tval_ff) * PA_W'(bstride_ff);
               prod_b_ff <= PB_W'(shard_ff) * PB_W'(lblocks_ff);
               st_ff     <= S_ADD;
            end
            S_ADD: begin
               if (wrap) begin
                  pos_ff       <= '0;
                  shard_run_ff <= 1'b1;
               end else begin
                  pos_ff <= pos_next[AW-1:0];
               end
               rsp_index_ff <= base_sum[IDX_W-1:0];
               rsp_last_ff  <= (local_eff == LW'(1));
               cnt_ff       <= LW'(1);
               if (local_eff != '0) begin
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= S_EMIT;
               end else begin
                  st_ff <= S_DRAIN;
               end
            end
            S_EMIT: begin
               if (cnt_ff == local_eff) begin
                  rsp_valid_ff <= 1'b0;
                  st_ff        <= S_DRAIN;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= rsp_index_ff + IDX_W'(1);
                  rsp_last_ff  <= ((cnt_ff + LW'(1)) == local_eff);
                  cnt_ff       <= cnt_ff + LW'(1);
               end
            end
            S_DRAIN: begin
               if (!shard_run_ff || div_done) begin
                  st_ff <= S_IDLE;
               end
            end
            default: begin
               st_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_last_block  = rsp_valid_ff && rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_WR_T) |-> (tgt_ff >= pos_ff) && (CW'(tgt_ff) < count_eff))
      else $error("swap target outside the unshuffled range");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_block) |=>
         (rsp_valid && (rsp_block_index == $past(rsp_block_index) + IDX_W'(1))))
      else $error("block indices of one transaction not consecutive");

   a_no_start_clear: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_CLEAR) |-> !accept)
      else $error("transaction accepted during table clearing");
`endif

endmodule

/* tb/tb_shuffled_batch_index_generator_core.sv */
// Self-checking testbench for shuffled_batch_index_generator_core: feeds random words,
// mirrors the incremental shuffle and block index math, and checks every result transaction.
// Depends on sbig_pkg and the core RTL.
module tb_shuffled_batch_index_generator_core;
   import sbig_pkg::*;

   localparam int TABLE_DEPTH   = 4096;
   localparam int NUM_LOCAL     = 64;
   localparam int SHARD_LIMIT   = 1024;
   localparam int REG_SPARE_LO  = 5;
   localparam int REG_SPARE_HI  = 7;
   localparam int SETTLE_CYCLES = 300;
   localparam int STALL_LIMIT   = 20000;
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_ITEMS   = 30;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [IDX_W-1:0] idx_val;
      logic             last_block;
   } block_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [RANDOM_W-1:0]   req_random_word = '0;
   logic                  rsp_valid;
   logic [IDX_W-1:0]      rsp_block_index;
   logic                  rsp_last_block;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // mirrored registers and shuffle state
   logic [BCOUNT_W-1:0]   batch_count_q;
   logic [BSTRIDE_W-1:0]  stride_q;
   logic [LBLOCKS_W-1:0]  local_blocks_q;
   logic [SCOUNT_W-1:0]   shard_count_q;
   logic [SFIRST_W-1:0]   first_shard_q;
   logic [11:0]           batch_table [TABLE_DEPTH];
   int unsigned           shuffle_pos;
   int unsigned           shard_now;

   logic [RANDOM_W-1:0]   pending_words [$];
   block_result_type      expected_blocks [$];
   bit                    steady = 1'b0;
   int                    idle_left = 0;
   int                    mismatch_count = 0;
   int                    quiet_cycles = 0;

   shuffled_batch_index_generator_core #(
      .MAX_BATCHES      (TABLE_DEPTH),
      .MAX_LOCAL_BLOCKS (NUM_LOCAL),
      .MAX_SHARDS       (SHARD_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_block_index (rsp_block_index),
      .rsp_last_block  (rsp_last_block),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void shuffle_step(input logic [RANDOM_W-1:0] word);
      int unsigned      span;
      int unsigned      shards;
      int unsigned      local_n;
      int unsigned      pos;
      int unsigned      target;
      logic [11:0]      picked;
      logic [63:0]      base;
      block_result_type res;
      span    = (batch_count_q == 0) ? 1 :
                (batch_count_q > TABLE_DEPTH) ? TABLE_DEPTH : batch_count_q;
      shards  = (shard_count_q == 0) ? 1 :
                (shard_count_q > SHARD_LIMIT) ? SHARD_LIMIT : shard_count_q;
      local_n = (local_blocks_q > NUM_LOCAL) ? NUM_LOCAL : local_blocks_q;
      pos     = (shuffle_pos >= span) ? 0 : shuffle_pos;
      target  = 32'(word % 64'(span - pos)) + pos;
      picked  = batch_table[target];
      batch_table[target] = batch_table[pos];
      batch_table[pos] = picked;
      // shard offset uses the raw local count, not the saturated one
      base = 64'(picked) * 64'(stride_q) + 64'(shard_now) * 64'(local_blocks_q);
      for (int unsigned i = 0; i < local_n; i++) begin
         res.idx_val    = IDX_W'(base + 64'(i));
         res.last_block = (i + 1 == local_n);
         expected_blocks.insert(expected_blocks.size(), res);
      end
      pos++;
      if (pos >= span) begin
         pos = 0;
         shard_now = (shard_now + 1) % shards;
      end
      shuffle_pos = pos;
   endfunction

   function automatic void add_word(input logic [RANDOM_W-1:0] word);
      pending_words.insert(pending_words.size(), word);
   endfunction

   // random noise above the register width, which the block must drop
   function automatic logic [CSR_DATA_W-1:0] fill_upper(input int unsigned value,
                                                        input int width);
      logic [CSR_DATA_W-1:0] mask;
      mask = (CSR_DATA_W'(1) << width) - 1'b1;
      return (CSR_DATA_W'($urandom) & ~mask) | (CSR_DATA_W'(value) & mask);
   endfunction

   // caller stands just after a rising edge; csr_valid is left high
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_BATCH_COUNT:     batch_count_q  = data[BCOUNT_W-1:0];
         REG_BLOCKS_IN_BATCH: stride_q       = data[BSTRIDE_W-1:0];
         REG_BLOCKS_IN_LOCAL: local_blocks_q = data[LBLOCKS_W-1:0];
         REG_SHARD_COUNT:     shard_count_q  = data[SCOUNT_W-1:0];
         REG_FIRST_SHARD: begin
            first_shard_q = data[SFIRST_W-1:0];
            shard_now     = first_shard_q;
         end
         default: ;
      endcase
   endtask

   task automatic load_regs(input int unsigned count, input int unsigned stride,
                            input int unsigned local_n, input int unsigned shards,
                            input int unsigned first);
      write_reg(REG_BATCH_COUNT, fill_upper(count, BCOUNT_W));
      write_reg(REG_BLOCKS_IN_BATCH, fill_upper(stride, BSTRIDE_W));
      write_reg(REG_BLOCKS_IN_LOCAL, fill_upper(local_n, LBLOCKS_W));
      write_reg(REG_SHARD_COUNT, fill_upper(shards, SCOUNT_W));
      write_reg(REG_FIRST_SHARD, fill_upper(first, SFIRST_W));
      csr_valid <= 1'b0;
   endtask

   // all words accepted, all results in, then room for a request with no results
   task automatic drain();
      while (pending_words.size() != 0 || start) @(posedge clock);
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) shuffle_step(req_random_word);
         if (start && busy) begin
            // hold the pending transaction
         end else if (idle_left > 0) begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (pending_words.size() != 0 && !steady && $urandom_range(0, 3) == 0) begin
            start     <= 1'b0;
            idle_left <= $urandom_range(0, 4);
         end else if (pending_words.size() != 0) begin
            start           <= 1'b1;
            req_random_word <= pending_words.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      block_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected result: index=%0d last_block=%0b",
                        rsp_block_index, rsp_last_block);
            mismatch_count++;
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_block_index !== want.idx_val || rsp_last_block !== want.last_block) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("mismatch: index exp %0d got %0d, last_block exp %0b got %0b",
                           want.idx_val, rsp_block_index, want.last_block, rsp_last_block);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_shuffled_batch_index_generator_core: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned pick;
      for (int i = 0; i < TABLE_DEPTH; i++) batch_table[i] = 12'(i);
      batch_count_q  = 1;
      stride_q       = 1;
      local_blocks_q = 1;
      shard_count_q  = 1;
      first_shard_q  = 0;
      shuffle_pos    = 0;
      shard_now      = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings, extreme words
      add_word('0);
      add_word('1);
      drain();

      // full table, widest stride: index wrap, max results, shard at top
      load_regs(4096, 131071, 64, 1024, 1023);
      add_word(64'd4095);
      add_word('0);
      add_word(64'h8000_0000_0000_0000);
      drain();

      // table shrinks under the position, no results, zero shards, shard past count
      load_regs(2, 77, 0, 0, 5);
      add_word(64'h5555_5555_5555_5555);
      add_word(64'hAAAA_AAAA_AAAA_AAAA);
      add_word(64'd1);
      drain();

      // zero batches, oversized local count and shard count, zero stride
      load_regs(0, 0, 127, 2047, 2);
      add_word(64'hAAAA_AAAA_AAAA_AAAA);
      add_word(64'h5555_5555_5555_5555);
      drain();

      // batch count above the table size, unknown register indexes
      load_regs(8191, 1, 1, 5, 0);
      for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
         write_reg(CSR_IDX_W'(i), CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      add_word('1);
      add_word(64'hFFFF_FFFF_0000_0000);
      add_word(64'h0000_0000_FFFF_FFFF);
      drain();

      for (int p = 0; p < RAND_PHASES; p++) begin
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_BATCH_COUNT, fill_upper(($urandom_range(0, 3) != 0) ?
                      $urandom_range(1, 9) : $urandom_range(0, 8191), BCOUNT_W));
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_BLOCKS_IN_BATCH, CSR_DATA_W'($urandom));
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_BLOCKS_IN_LOCAL, fill_upper(($urandom_range(0, 3) != 0) ?
                      $urandom_range(0, 12) : $urandom_range(0, 127), LBLOCKS_W));
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_SHARD_COUNT, fill_upper(($urandom_range(0, 1) != 0) ?
                      $urandom_range(0, 6) : $urandom_range(0, 2047), SCOUNT_W));
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_FIRST_SHARD, CSR_DATA_W'($urandom));
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                      CSR_DATA_W'($urandom));
         csr_valid <= 1'b0;
         steady = (p == RAND_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0)      add_word('1);
            else if (pick == 1) add_word(RANDOM_W'($urandom_range(0, 15)));
            else                add_word({$urandom, $urandom});
         end
         drain();
      end

      if (mismatch_count == 0 && expected_blocks.size() == 0) begin
         $display("tb_shuffled_batch_index_generator_core: clean");
      end else begin
         $display("tb_shuffled_batch_index_generator_core: errors");
      end
      $finish;
   end

endmodule
